### hw/rtl/hsr_pkg.sv
// shared types, constants and codes for the heap sort record block
package hsr_pkg;

	// capacity of the record store
	localparam int MAX_RECORDS = 32;
	// store address, record count (0..MAX) and child index (up to 2*MAX) widths
	localparam int AW = $clog2(MAX_RECORDS);
	localparam int CW = $clog2(MAX_RECORDS + 1);
	localparam int JW = CW + 1;

	// one loaded record beat
	typedef struct packed {
		logic signed [31:0] rec_key;
		logic signed [31:0] rec_info;
		logic               is_last;
	} rec_beat_t;

	// one sorted result beat
	typedef struct packed {
		logic signed [31:0] out_key;
		logic signed [31:0] out_info;
		logic               out_last;
	} res_beat_t;

	// one store entry
	typedef struct packed {
		logic signed [31:0] key;
		logic signed [31:0] info;
	} entry_t;

	// controller states
	typedef enum logic [3:0] {
		ST_LOAD,
		ST_START,
		ST_BUILD_RD,
		ST_HOLD,
		ST_SIFT_RD,
		ST_SIFT_CMP,
		ST_SIFT_WR,
		ST_BUILD_NEXT,
		ST_SORT_INIT,
		ST_SWAP_RD,
		ST_SWAP_WR,
		ST_SORT_NEXT,
		ST_EMIT_INIT,
		ST_EMIT_RD,
		ST_EMIT_LD,
		ST_EMIT_WAIT
	} state_t;

	// heap phase
	typedef enum logic {
		PH_BUILD,
		PH_SORT
	} phase_t;

	// datapath operations
	typedef enum logic [3:0] {
		OP_LOAD,
		OP_START,
		OP_RD_NODE,
		OP_HOLD,
		OP_RD_KIDS,
		OP_CMP,
		OP_WR_HELD,
		OP_BUILD_DEC,
		OP_SORT_INIT,
		OP_RD_SWAP,
		OP_WR_SWAP,
		OP_SORT_DEC,
		OP_EMIT_INIT,
		OP_RD_EMIT,
		OP_LD_OUT,
		OP_WAIT_OUT
	} op_t;

	// controller to datapath
	typedef struct packed {
		op_t op;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic in_beat;
		logic in_last;
		logic half_zero;
		logic j_gt_m;
		logic stop;
		logic i_one;
		logic i_two;
		logic out_taken;
		logic emit_last;
	} dp_status_t;

endpackage

### hw/rtl/hsr_ctrl.sv
// controller state machine that sequences load, heap build, sort and emit
module hsr_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  hsr_pkg::dp_status_t st,
	output hsr_pkg::dp_cmd_t    cmd
);
	import hsr_pkg::*;

	state_t state_q, state_d;
	phase_t phase_q, phase_d;

	// state and phase registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			phase_q <= PH_BUILD;
		end else begin
			state_q <= state_d;
			phase_q <= phase_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		phase_d = phase_q;
		case (state_q)
			ST_LOAD: begin
				if (st.in_beat && st.in_last) state_d = ST_START;
			end
			ST_START: begin
				phase_d = PH_BUILD;
				state_d = st.half_zero ? ST_EMIT_INIT : ST_BUILD_RD;
			end
			ST_BUILD_RD:  state_d = ST_HOLD;
			ST_HOLD:      state_d = ST_SIFT_RD;
			ST_SIFT_RD:   state_d = st.j_gt_m ? ST_SIFT_WR : ST_SIFT_CMP;
			ST_SIFT_CMP:  state_d = st.stop ? ST_SIFT_WR : ST_SIFT_RD;
			ST_SIFT_WR:   state_d = (phase_q == PH_BUILD) ? ST_BUILD_NEXT : ST_SORT_NEXT;
			ST_BUILD_NEXT: state_d = st.i_one ? ST_SORT_INIT : ST_BUILD_RD;
			ST_SORT_INIT: begin
				phase_d = PH_SORT;
				state_d = ST_SWAP_RD;
			end
			ST_SWAP_RD:   state_d = ST_SWAP_WR;
			ST_SWAP_WR:   state_d = ST_SIFT_RD;
			ST_SORT_NEXT: state_d = st.i_two ? ST_EMIT_INIT : ST_SWAP_RD;
			ST_EMIT_INIT: state_d = ST_EMIT_RD;
			ST_EMIT_RD:   state_d = ST_EMIT_LD;
			ST_EMIT_LD:   state_d = ST_EMIT_WAIT;
			ST_EMIT_WAIT: begin
				if (st.out_taken) state_d = st.emit_last ? ST_LOAD : ST_EMIT_RD;
			end
			default:      state_d = ST_LOAD;
		endcase
	end

	// datapath command per state
	always_comb begin
		case (state_q)
			ST_LOAD:       cmd.op = OP_LOAD;
			ST_START:      cmd.op = OP_START;
			ST_BUILD_RD:   cmd.op = OP_RD_NODE;
			ST_HOLD:       cmd.op = OP_HOLD;
			ST_SIFT_RD:    cmd.op = OP_RD_KIDS;
			ST_SIFT_CMP:   cmd.op = OP_CMP;
			ST_SIFT_WR:    cmd.op = OP_WR_HELD;
			ST_BUILD_NEXT: cmd.op = OP_BUILD_DEC;
			ST_SORT_INIT:  cmd.op = OP_SORT_INIT;
			ST_SWAP_RD:    cmd.op = OP_RD_SWAP;
			ST_SWAP_WR:    cmd.op = OP_WR_SWAP;
			ST_SORT_NEXT:  cmd.op = OP_SORT_DEC;
			ST_EMIT_INIT:  cmd.op = OP_EMIT_INIT;
			ST_EMIT_RD:    cmd.op = OP_RD_EMIT;
			ST_EMIT_LD:    cmd.op = OP_LD_OUT;
			ST_EMIT_WAIT:  cmd.op = OP_WAIT_OUT;
			default:       cmd.op = OP_WAIT_OUT;
		endcase
	end

endmodule

### hw/rtl/hsr_dp.sv
// datapath: record store, sift index registers, key compare and result register
module hsr_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  hsr_pkg::dp_cmd_t    cmd,
	output hsr_pkg::dp_status_t st,
	input  hsr_pkg::rec_beat_t  rec,
	input  logic                rec_valid,
	output logic                rec_stall,
	output hsr_pkg::res_beat_t  res,
	output logic                res_valid,
	input  logic                res_stall
);
	import hsr_pkg::*;

	// record store, one write and two registered reads per cycle
	entry_t mem_q [MAX_RECORDS];
	entry_t rd_a_q, rd_b_q;

	logic [CW-1:0] count_q;
	logic [CW-1:0] i_q, s_q, m_q;
	logic [JW-1:0] j_q;
	logic [AW-1:0] k_q;
	entry_t        held_q;
	res_beat_t     res_q;
	logic          res_valid_q;

	logic          in_beat, out_taken;
	logic [CW-1:0] s_m1, i_m1, child_node;
	logic [JW-1:0] j_m1;
	logic          pick_right, stop, emit_last;
	entry_t        child;
	logic          wr_en;
	logic [AW-1:0] wr_addr, rd_a_addr, rd_b_addr;
	entry_t        wr_data;

	// handshakes
	assign rec_stall = (cmd.op != OP_LOAD);
	assign in_beat   = rec_valid && !rec_stall;
	assign out_taken = res_valid_q && !res_stall;
	assign res       = res_q;
	assign res_valid = res_valid_q;

	// index arithmetic and child selection
	assign s_m1       = s_q - CW'(1);
	assign i_m1       = i_q - CW'(1);
	assign j_m1       = j_q - JW'(1);
	assign pick_right = (j_q < JW'(m_q)) && (rd_a_q.key < rd_b_q.key);
	assign child      = pick_right ? rd_b_q : rd_a_q;
	assign child_node = j_q[CW-1:0] + CW'(pick_right);
	assign stop       = !(held_q.key < child.key);
	assign emit_last  = (CW'(k_q) == count_q - CW'(1));

	// status to controller
	always_comb begin
		st.in_beat   = in_beat;
		st.in_last   = rec.is_last;
		st.half_zero = (count_q[CW-1:1] == '0);
		st.j_gt_m    = (j_q > JW'(m_q));
		st.stop      = stop;
		st.i_one     = (i_q == CW'(1));
		st.i_two     = (i_q == CW'(2));
		st.out_taken = out_taken;
		st.emit_last = emit_last;
	end

	// store port addresses and write data
	always_comb begin
		wr_en     = 1'b0;
		wr_addr   = '0;
		wr_data   = held_q;
		rd_a_addr = '0;
		rd_b_addr = '0;
		case (cmd.op)
			OP_LOAD: begin
				wr_en   = in_beat && (count_q < CW'(MAX_RECORDS));
				wr_addr = count_q[AW-1:0];
				wr_data = '{key: rec.rec_key, info: rec.rec_info};
			end
			OP_RD_NODE: rd_a_addr = i_m1[AW-1:0];
			OP_RD_KIDS: begin
				rd_a_addr = j_m1[AW-1:0];
				rd_b_addr = j_q[AW-1:0];
			end
			OP_CMP: begin
				wr_en   = !stop;
				wr_addr = s_m1[AW-1:0];
				wr_data = child;
			end
			OP_WR_HELD: begin
				wr_en   = 1'b1;
				wr_addr = s_m1[AW-1:0];
				wr_data = held_q;
			end
			OP_RD_SWAP: rd_b_addr = i_m1[AW-1:0];
			OP_WR_SWAP: begin
				wr_en   = 1'b1;
				wr_addr = i_m1[AW-1:0];
				wr_data = rd_a_q;
			end
			OP_RD_EMIT: rd_a_addr = k_q;
			default: ;
		endcase
	end

	// store write and registered reads
	always_ff @(posedge clk) begin
		if (wr_en) mem_q[wr_addr] <= wr_data;
		rd_a_q <= mem_q[rd_a_addr];
		rd_b_q <= mem_q[rd_b_addr];
	end

	// record count and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (cmd.op == OP_LOAD && in_beat && count_q < CW'(MAX_RECORDS))
				count_q <= count_q + CW'(1);
			if (cmd.op == OP_WAIT_OUT && out_taken && emit_last)
				count_q <= '0;
			if (cmd.op == OP_LD_OUT)
				res_valid_q <= 1'b1;
			else if (out_taken)
				res_valid_q <= 1'b0;
		end
	end

	// sift indices, held record and result beat
	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_START: begin
				i_q <= count_q >> 1;
				m_q <= count_q;
			end
			OP_RD_NODE: s_q <= i_q;
			OP_HOLD: begin
				held_q <= rd_a_q;
				j_q    <= {s_q, 1'b0};
			end
			OP_CMP: begin
				if (!stop) begin
					s_q <= child_node;
					j_q <= {child_node, 1'b0};
				end
			end
			OP_BUILD_DEC: i_q <= i_m1;
			OP_SORT_INIT: i_q <= count_q;
			OP_WR_SWAP: begin
				held_q <= rd_b_q;
				s_q    <= CW'(1);
				j_q    <= JW'(2);
				m_q    <= i_m1;
			end
			OP_SORT_DEC: i_q <= i_m1;
			OP_EMIT_INIT: k_q <= '0;
			OP_LD_OUT: begin
				res_q <= '{out_key: rd_a_q.key, out_info: rd_a_q.info, out_last: emit_last};
			end
			OP_WAIT_OUT: begin
				if (out_taken && !emit_last) k_q <= k_q + AW'(1);
			end
			default: ;
		endcase
	end

endmodule

### hw/rtl/heap_sort_records.sv
// top level of the record loader and ascending heap sorter
//
//  channel  | role   | payload     | handshake
//  ---------+--------+-------------+----------------------
//  rec      | input  | rec_beat_t  | rec_valid / rec_stall
//  res      | output | res_beat_t  | res_valid / res_stall
//
// loading takes one record beat per cycle while rec_stall is low; beats past MAX_RECORDS are dropped
// the sort uses the store's single write port and two registered read ports;
// each sift level reads both children, then compares and moves the larger one up
// each sorted record is then read, loaded into the result register and held while res_stall is high
// rec_stall stays high from the closing beat until the final result is taken
// reset clears the controller, the record count and res_valid
module heap_sort_records (
	input  logic               clk,
	input  logic               arst_n,
	input  hsr_pkg::rec_beat_t rec,
	input  logic               rec_valid,
	output logic               rec_stall,
	output hsr_pkg::res_beat_t res,
	output logic               res_valid,
	input  logic               res_stall
);
	import hsr_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t st;

	// sequencer
	hsr_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.st     (st),
		.cmd    (cmd)
	);

	// store and compare datapath
	hsr_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.st        (st),
		.rec       (rec),
		.rec_valid (rec_valid),
		.rec_stall (rec_stall),
		.res       (res),
		.res_valid (res_valid),
		.res_stall (res_stall)
	);

endmodule

### hw/rtl/hsr_checker.sv
// port level checks for the heap sorter, bound to the top level
module hsr_checker (
	input logic               clk,
	input logic               arst_n,
	input hsr_pkg::rec_beat_t rec,
	input logic               rec_valid,
	input logic               rec_stall,
	input hsr_pkg::res_beat_t res,
	input logic               res_valid,
	input logic               res_stall
);
	import hsr_pkg::*;

	// no record beat is taken while a result is on offer
	a_no_load_while_emit: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> rec_stall)
		else $error("record beat accepted during emission");

	// the closing beat stops the input side
	a_close_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		(rec_valid && !rec_stall && rec.is_last) |=> rec_stall)
		else $error("input not stalled after closing beat");

	// after the final result the block is back to loading
	a_final_reopens: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res_stall && res.out_last) |=> (!res_valid && !rec_stall))
		else $error("block not reopened after final result");

	// a stalled result beat holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_stall) |=> (res_valid && $stable(res)))
		else $error("stalled result beat changed");

endmodule

bind heap_sort_records hsr_checker u_hsr_checker (.*);

### tb/sv/tb.sv
// testbench for heap_sort_records: loads random record sets and checks the sorted output
`timescale 1ns / 100ps

module tb;
	import hsr_pkg::*;

	localparam int IDLE_LIMIT   = 5000;
	localparam int RANDOM_ITEMS = 390;
	localparam int DRAIN_CYCLES = 40;

	logic      clk;
	logic      arst_n;
	rec_beat_t rec;
	logic      rec_valid;
	logic      rec_stall;
	res_beat_t res;
	logic      res_valid;
	logic      res_stall = 1'b0;

	// records of the open set, as the block holds them
	logic signed [31:0] held_key [MAX_RECORDS];
	logic signed [31:0] held_info [MAX_RECORDS];
	int                 held_count;
	// sorted records still to come out of the block
	res_beat_t          pending_sorted [$];
	int                 error_count = 0;
	int                 burst_left;

	heap_sort_records u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.rec       (rec),
		.rec_valid (rec_valid),
		.rec_stall (rec_stall),
		.res       (res),
		.res_valid (res_valid),
		.res_stall (res_stall)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// sift node s (1-based) down over heap nodes 1..m, larger child wins, left on ties
	function automatic void sift_held(input int s, input int m);
		logic signed [31:0] hk;
		logic signed [31:0] hi;
		int                 j;
		hk = held_key[s - 1];
		hi = held_info[s - 1];
		j = 2 * s;
		while (j <= m) begin
			if (j < m && held_key[j - 1] < held_key[j])
				j++;
			if (!(hk < held_key[j - 1]))
				break;
			held_key[s - 1]  = held_key[j - 1];
			held_info[s - 1] = held_info[j - 1];
			s = j;
			j = 2 * j;
		end
		held_key[s - 1]  = hk;
		held_info[s - 1] = hi;
	endfunction

	// store an accepted beat; on the closing beat heap-sort the set and queue the results
	function automatic void record_and_sort(input rec_beat_t b);
		res_beat_t          r;
		logic signed [31:0] tk;
		logic signed [31:0] ti;
		int                 i;
		if (held_count < MAX_RECORDS) begin
			held_key[held_count]  = b.rec_key;
			held_info[held_count] = b.rec_info;
			held_count++;
		end
		if (b.is_last) begin
			for (i = held_count / 2; i > 0; i--)
				sift_held(i, held_count);
			for (i = held_count; i > 1; i--) begin
				tk = held_key[0];
				ti = held_info[0];
				held_key[0]      = held_key[i - 1];
				held_info[0]     = held_info[i - 1];
				held_key[i - 1]  = tk;
				held_info[i - 1] = ti;
				sift_held(1, i - 1);
			end
			for (i = 0; i < held_count; i++) begin
				r.out_key  = held_key[i];
				r.out_info = held_info[i];
				r.out_last = (i == held_count - 1);
				pending_sorted.push_back(r);
			end
			held_count = 0;
		end
	endfunction

	task automatic report_mismatch(input string what, input logic signed [31:0] got,
			input logic signed [31:0] want);
		$display("tb: mismatch %s: got %0d want %0d at %0t", what, got, want, $time);
		error_count++;
	endtask

	// send one record beat; bursts of random length with random gaps between them
	task automatic send_record(input logic signed [31:0] k, input logic signed [31:0] inf,
			input logic last);
		rec_beat_t b;
		b.rec_key  = k;
		b.rec_info = inf;
		b.is_last  = last;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80)
			                                         : $urandom_range(1, 8);
			repeat ($urandom_range(0, 5)) @(negedge clk);
		end
		burst_left--;
		@(negedge clk);
		rec       <= b;
		rec_valid <= 1'b1;
		do @(posedge clk); while (rec_stall);
		record_and_sort(b);
		if (burst_left == 0) begin
			@(negedge clk);
			rec_valid <= 1'b0;
		end
	endtask

	// drop valid and wait for every expected result to come out
	task automatic hold_until_drained();
		if (rec_valid) begin
			@(negedge clk);
			rec_valid <= 1'b0;
		end
		burst_left = 0;
		while (pending_sorted.size() != 0)
			@(posedge clk);
	endtask

	// a set of one record, extreme key and payload
	task automatic test_single_record();
		send_record(32'sh8000_0000, 32'sh7fff_ffff, 1'b1);
	endtask

	// extreme keys with duplicates, so ties of both signs meet in the heap
	task automatic test_key_extremes();
		send_record(32'sh7fff_ffff, 32'sh8000_0000, 1'b0);
		send_record(32'sh8000_0000, 32'sh7fff_ffff, 1'b0);
		send_record(32'sh0000_0000, -32'sd1, 1'b0);
		send_record(-32'sd1, 32'sh0000_0000, 1'b0);
		send_record(32'sh7fff_ffff, 32'sd1, 1'b0);
		send_record(32'sh8000_0000, -32'sd2, 1'b1);
	endtask

	// a full store, then one more beat that is dropped but still closes the set
	task automatic test_full_set();
		int i;
		for (i = 0; i < MAX_RECORDS; i++)
			send_record($urandom, $urandom, 1'b0);
		send_record($urandom, $urandom, 1'b1);
	endtask

	// random sets: mostly small, some full or overflowing, keys of several shapes
	task automatic test_random_sets();
		int                 sent;
		int                 set_no;
		int                 n;
		int                 shape;
		int                 k;
		int                 pick;
		logic signed [31:0] key;
		logic signed [31:0] base;
		logic signed [31:0] step;
		sent   = 0;
		set_no = 0;
		while (sent < RANDOM_ITEMS) begin
			pick = $urandom_range(0, 9);
			if (pick < 5)
				n = $urandom_range(1, 6);
			else if (pick < 8)
				n = $urandom_range(7, MAX_RECORDS);
			else if (pick == 8)
				n = MAX_RECORDS;
			else
				n = $urandom_range(MAX_RECORDS + 1, MAX_RECORDS + 8);
			shape = $urandom_range(0, 4);
			base  = $urandom;
			step  = $urandom_range(0, 1000);
			for (k = 0; k < n; k++) begin
				case (shape)
					0: key = $urandom;
					// narrow range, many equal keys
					1: key = $signed(32'($urandom_range(0, 6))) - 32'sd3;
					2: begin
						case ($urandom_range(0, 3))
							0: key = 32'sh8000_0000;
							1: key = 32'sh7fff_ffff;
							2: key = 32'sh0000_0000;
							default: key = -32'sd1;
						endcase
					end
					3: key = base + step * k;
					default: key = base - step * k;
				endcase
				send_record(key, $urandom, k == n - 1);
			end
			sent += n;
			set_no++;
			if (set_no % 7 == 0)
				hold_until_drained();
		end
	endtask

	// receiver stall pattern: phases of no stall, random stall and heavy stall
	int stall_mode = 0;
	int stall_left = 0;
	always @(negedge clk) begin
		if (stall_left == 0) begin
			stall_mode = $urandom_range(0, 2);
			stall_left = $urandom_range(20, 200);
		end
		stall_left--;
		case (stall_mode)
			0: res_stall <= 1'b0;
			1: res_stall <= $urandom_range(0, 1);
			default: res_stall <= ($urandom_range(0, 7) != 0);
		endcase
	end

	// compare each result beat with the oldest expected record
	always @(posedge clk) begin : check_results
		res_beat_t want;
		if (arst_n && res_valid && !res_stall) begin
			if (pending_sorted.size() == 0) begin
				report_mismatch("unexpected result key", res.out_key, 32'sd0);
			end else begin
				want = pending_sorted.pop_front();
				if (res.out_key !== want.out_key)
					report_mismatch("out_key", res.out_key, want.out_key);
				if (res.out_info !== want.out_info)
					report_mismatch("out_info", res.out_info, want.out_info);
				if (res.out_last !== want.out_last)
					report_mismatch("out_last", 32'(res.out_last), 32'(want.out_last));
			end
		end
	end

	// watchdog on cycles without any beat
	int idle_cycles = 0;
	always @(posedge clk) begin
		if ((rec_valid && !rec_stall) || (res_valid && !res_stall))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("tb: no beat for %0d cycles", IDLE_LIMIT);
			$display("tb: done, errors");
			$finish;
		end
	end

	// reset, tests in turn, drain and verdict
	initial begin
		arst_n      = 1'b0;
		rec         = '0;
		rec_valid   = 1'b0;
		held_count  = 0;
		burst_left  = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_single_record();
		test_key_extremes();
		test_full_set();
		hold_until_drained();
		test_random_sets();
		hold_until_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (error_count == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end

endmodule
